/* rtl/msp_exit_pkg.sv */
// Shared types and constants for the request frame exit detector.
`timescale 1ns / 1ps

package msp_exit_pkg;

   // Frame header bytes and the reset value of the exit command register.
   localparam logic [7:0] SYNC_DOLLAR = 8'h24;
   localparam logic [7:0] SYNC_EM     = 8'h4D;
   localparam logic [7:0] SYNC_LT     = 8'h3C;
   localparam logic [7:0] EXIT_RESET  = 8'hF4;

   // Parser phases, one-hot coded.
   typedef enum logic [5:0] {
      PH_IDLE   = 6'b000001,
      PH_DOLLAR = 6'b000010,
      PH_EM     = 6'b000100,
      PH_ARROW  = 6'b001000,
      PH_SIZE   = 6'b010000,
      PH_BODY   = 6'b100000
   } phase_type;

   // Result of one received word.
   typedef struct packed {
      logic       exit_found;
      logic       frame_valid;
      logic [7:0] command_code;
   } result_type;

endpackage

/* rtl/msp_exit_parser.sv */
// Frame parser state and its next-state logic for one received word.
`timescale 1ns / 1ps

module msp_exit_parser
   import msp_exit_pkg::*;
#(
   parameter int MAX_PAYLOAD = 10
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       advance,
   input  logic [7:0] rx_byte,
   input  logic [7:0] exit_command,
   output result_type result
);

   localparam int         SizeWidth      = $clog2(MAX_PAYLOAD + 1);
   localparam logic [7:0] MaxPayloadByte = 8'(MAX_PAYLOAD);

   phase_type            phase_ff, phase_in;
   logic [SizeWidth-1:0] size_ff, size_in;
   logic [SizeWidth-1:0] count_ff, count_in;
   logic [7:0]           xor_ff, xor_in;
   logic [7:0]           cmd_ff, cmd_in;
   logic                 frame_ok;
   logic                 exit_ok;

   // Next state and flags for the word now presented.
   always_comb begin
      phase_in = phase_ff;
      size_in  = size_ff;
      count_in = count_ff;
      xor_in   = xor_ff;
      cmd_in   = cmd_ff;
      frame_ok = 1'b0;
      exit_ok  = 1'b0;
      unique case (phase_ff)
         PH_DOLLAR: begin
            phase_in = (rx_byte == SYNC_EM) ? PH_EM : PH_IDLE;
         end
         PH_EM: begin
            phase_in = (rx_byte == SYNC_LT) ? PH_ARROW : PH_IDLE;
         end
         PH_ARROW: begin
            if (rx_byte > MaxPayloadByte) begin
               phase_in = PH_IDLE;
            end else begin
               size_in  = rx_byte[SizeWidth-1:0];
               count_in = '0;
               xor_in   = rx_byte;
               phase_in = PH_SIZE;
            end
         end
         PH_SIZE: begin
            cmd_in   = rx_byte;
            xor_in   = xor_ff ^ rx_byte;
            phase_in = PH_BODY;
         end
         PH_BODY: begin
            if (count_ff < size_ff) begin
               xor_in   = xor_ff ^ rx_byte;
               count_in = count_ff + SizeWidth'(1);
            end else begin
               // Checksum word: the frame ends here whether it is good or not.
               if (xor_ff == rx_byte) begin
                  frame_ok = 1'b1;
                  if (cmd_ff == exit_command && size_ff == '0) begin
                     exit_ok = 1'b1;
                  end
               end
               phase_in = PH_IDLE;
            end
         end
         default: begin
            phase_in = (rx_byte == SYNC_DOLLAR) ? PH_DOLLAR : PH_IDLE;
         end
      endcase
   end

   assign result.exit_found   = exit_ok;
   assign result.frame_valid  = frame_ok;
   assign result.command_code = cmd_in;

   // Parser state advances on each accepted word.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         size_ff  <= '0;
         count_ff <= '0;
         xor_ff   <= '0;
         cmd_ff   <= '0;
      end else if (advance) begin
         phase_ff <= phase_in;
         size_ff  <= size_in;
         count_ff <= count_in;
         xor_ff   <= xor_in;
         cmd_ff   <= cmd_in;
      end
   end

`ifndef SYNTHESIS
   // The payload counter never runs past the frame size.
   assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_BODY |-> count_ff <= size_ff)
      else $error("payload count exceeds frame size");

   // An oversized size word sends the parser back to idle.
   assert property (@(posedge clock) disable iff (reset)
      advance && phase_ff == PH_ARROW && rx_byte > MaxPayloadByte |=> phase_ff == PH_IDLE)
      else $error("oversized frame not dropped");

   // A payload word moves the counter on by exactly one.
   assert property (@(posedge clock) disable iff (reset)
      advance && phase_ff == PH_BODY && count_ff < size_ff
      |=> count_ff == $past(count_ff) + SizeWidth'(1))
      else $error("payload count did not advance");
`endif

endmodule

/* rtl/msp_exit_frame_parser_core.sv */
// Top level of the request frame exit detector.
`timescale 1ns / 1ps

// Takes one received word per cycle unless stalled and recognises request frames
// of the form '$', 'M', '<', size, command, payload, checksum, where the
// checksum is the XOR of size, command and payload. Every accepted word gives
// exactly one result word in the next cycle: frame_valid marks a checksum word
// that matched, exit_found additionally marks an empty frame carrying the exit
// command, and command_code is the command of the frame in progress or the last
// one seen. A new word can be accepted in every cycle; the single result register
// is the only stage, and req_stall is raised only while that register holds a
// result that the receiver is stalling. The exit command is to be written
// through the csr_ port while the block is idle (not enforced); resets to 0xF4.

module msp_exit_frame_parser_core
   import msp_exit_pkg::*;
#(
   parameter int MAX_PAYLOAD = 10
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_rx_byte,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic       rsp_exit_found,
   output logic       rsp_frame_valid,
   output logic [7:0] rsp_command_code,
   input  logic       csr_write_en,
   input  logic [7:0] csr_write_data
);

   logic [7:0] exit_command_ff;
   logic       rsp_valid_ff;
   result_type result;
   result_type rsp_word_ff;
   logic       req_take;

   // Exit command register.
   always_ff @(posedge clock) begin
      if (reset) begin
         exit_command_ff <= EXIT_RESET;
      end else if (csr_write_en) begin
         exit_command_ff <= csr_write_data;
      end
   end

   // Input is taken whenever the result register is free or being emptied.
   assign req_stall = rsp_valid_ff && rsp_stall;
   assign req_take  = req_valid && !req_stall;

   msp_exit_parser #(
      .MAX_PAYLOAD(MAX_PAYLOAD)
   ) u_parser (
      .clock       (clock),
      .reset       (reset),
      .advance     (req_take),
      .rx_byte     (req_rx_byte),
      .exit_command(exit_command_ff),
      .result      (result)
   );

   // Result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_take) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         rsp_word_ff <= result;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_exit_found   = rsp_word_ff.exit_found;
   assign rsp_frame_valid  = rsp_word_ff.frame_valid;
   assign rsp_command_code = rsp_word_ff.command_code;

`ifndef SYNTHESIS
   // An exit is only ever reported on a frame that passed its checksum.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_word_ff.exit_found |-> rsp_word_ff.frame_valid)
      else $error("exit reported without a valid frame");

   // A pending stalled result always holds off the input side.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_stall |-> req_stall)
      else $error("input accepted over a stalled result");

   // A result appears only after an input word was taken.
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(req_valid && !req_stall))
      else $error("result without an accepted word");
`endif

endmodule
